// ===== rtl/pscq_pkg.sv =====
// ----------------------------------------------------------------------------
// pscq_pkg
// Shared types and constants for the pair-sum count query block.
// ----------------------------------------------------------------------------
`default_nettype none

package pscq_pkg;

  localparam int unsigned MAX_TERMS = 4096;
  localparam int unsigned ADDR_W    = $clog2(MAX_TERMS);
  localparam int unsigned TOTAL_W   = $clog2(MAX_TERMS + 1);
  localparam int unsigned VALUE_W   = 50;
  localparam int unsigned COUNT_W   = 24;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_CMP,
    S_SW_RD,
    S_SW_CMP
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] pair_count;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/pair_sum_count_query_top.sv =====
// ----------------------------------------------------------------------------
// pair_sum_count_query_top
// Sorted term table with append, clear and pair-sum count query.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  input     start_i, item_i, busy_o    taken when start_i & !busy_o
//  result    done_o, result_o           one-cycle strobe, always taken
//
//  clear, append and unused modes finish without going busy; the result shows the
//  cycle after the transaction. a query does a binary search (a read and a
//  compare state per step) and then a two-pointer sweep, also with a read
//  and a compare state per step, since the memory read is registered. busy_o
//  is high during a query only.
//  reset clears the term count; the table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_sum_count_query_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire pscq_pkg::in_t  item_i,
  output logic                busy_o,
  output logic                done_o,
  output pscq_pkg::out_t      result_o
);

  localparam int unsigned AW = pscq_pkg::ADDR_W;
  localparam int unsigned TW = pscq_pkg::TOTAL_W;
  localparam int unsigned VW = pscq_pkg::VALUE_W;
  localparam int unsigned CW = pscq_pkg::COUNT_W;

  pscq_pkg::state_e state_q, state_d;
  logic [TW-1:0]    total_q, total_d;
  logic [VW-1:0]    last_q, last_d;
  logic [VW-1:0]    x_q, x_d;
  logic [TW-1:0]    lo_q, lo_d;
  logic [TW-1:0]    hi_q, hi_d;
  logic [TW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    acc_q, acc_d;
  logic             done_q, done_d;
  pscq_pkg::out_t   result_q, result_d;

  logic             accept;
  logic             wr_en;
  logic [AW-1:0]    rd_addr_a;
  logic [AW-1:0]    rd_addr_b;
  logic [VW-1:0]    rd_data_a;
  logic [VW-1:0]    rd_data_b;
  logic [TW:0]      mid_sum;
  logic [TW-1:0]    mid;
  logic [TW-1:0]    hi_m1;
  logic [VW:0]      pair_sum;
  logic [TW-1:0]    span;

  assign accept    = start_i && (state_q == pscq_pkg::S_IDLE);
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[TW:1];
  assign hi_m1     = hi_q - TW'(1);
  assign pair_sum  = {1'b0, rd_data_a} + {1'b0, rd_data_b};
  assign span      = hi_q - idx_q;

  // port a serves the search and the low pointer, port b the high pointer
  assign rd_addr_a = (state_q == pscq_pkg::S_SW_RD) ? idx_q[AW-1:0] : mid[AW-1:0];
  assign rd_addr_b = hi_m1[AW-1:0];

  pscq_ram #(
    .WIDTH (VW),
    .DEPTH (pscq_pkg::MAX_TERMS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i (item_i.value),
    .raddr_i (rd_addr_a),
    .rdata_o (rd_data_a)
  );

  pscq_ram #(
    .WIDTH (VW),
    .DEPTH (pscq_pkg::MAX_TERMS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i (item_i.value),
    .raddr_i (rd_addr_b),
    .rdata_o (rd_data_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pscq_pkg::S_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    x_q      <= x_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    idx_q    <= idx_d;
    acc_q    <= acc_d;
    result_q <= result_d;
  end

  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    last_d   = last_q;
    x_d      = x_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    result_d = result_q;
    wr_en    = 1'b0;

    case (state_q)
      pscq_pkg::S_IDLE: begin
        if (accept) begin
          result_d.status     = pscq_pkg::ST_OK;
          result_d.pair_count = '0;
          case (item_i.mode)
            pscq_pkg::MODE_CLEAR: begin
              total_d = '0;
              done_d  = 1'b1;
            end
            pscq_pkg::MODE_APPEND: begin
              done_d = 1'b1;
              if (total_q >= TW'(pscq_pkg::MAX_TERMS)) begin
                result_d.status = pscq_pkg::ST_FULL;
              end else if ((total_q != '0) && (item_i.value <= last_q)) begin
                result_d.status = pscq_pkg::ST_ORDER;
              end else begin
                wr_en   = 1'b1;
                last_d  = item_i.value;
                total_d = total_q + TW'(1);
              end
            end
            pscq_pkg::MODE_QUERY: begin
              x_d     = item_i.value;
              lo_d    = '0;
              hi_d    = total_q;
              state_d = pscq_pkg::S_BS_RD;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      pscq_pkg::S_BS_RD: begin
        // search ends with lo = number of terms at most x
        if (lo_q >= hi_q) begin
          hi_d    = lo_q;
          idx_d   = '0;
          acc_d   = CW'(lo_q);
          state_d = pscq_pkg::S_SW_RD;
        end else begin
          state_d = pscq_pkg::S_BS_CMP;
        end
      end

      pscq_pkg::S_BS_CMP: begin
        if (rd_data_a <= x_q) begin
          lo_d = mid + TW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = pscq_pkg::S_BS_RD;
      end

      pscq_pkg::S_SW_RD: begin
        if (hi_q <= idx_q) begin
          result_d.status     = pscq_pkg::ST_OK;
          result_d.pair_count = acc_q;
          done_d              = 1'b1;
          state_d             = pscq_pkg::S_IDLE;
        end else begin
          state_d = pscq_pkg::S_SW_CMP;
        end
      end

      pscq_pkg::S_SW_CMP: begin
        if (pair_sum > {1'b0, x_q}) begin
          hi_d = hi_m1;
        end else begin
          acc_d = acc_q + CW'(span);
          idx_d = idx_q + TW'(1);
        end
        state_d = pscq_pkg::S_SW_RD;
      end

      default: begin
        state_d = pscq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o   = (state_q != pscq_pkg::S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== rtl/pscq_ram.sv =====
// ----------------------------------------------------------------------------
// pscq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pscq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
